/* rtl/biq_pkg.sv */
// Shared types and constants for the biquad IIR filter.
// No dependencies; imported by the filter top level, its checkers and the testbench.
package biq_pkg;

  localparam int CHAN_BITS = 3;
  localparam int COEF_BITS = 32;
  localparam int COEF_FRAC = 30;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic signed [COEF_BITS-1:0] COEF_ONE = 32'sh4000_0000;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } coef_reg_t;

endpackage

/* rtl/biq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the per-channel filter history.
module biq_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/biquad_iir_filter.sv */
// Multichannel biquad IIR filter, direct form I, with per-channel history in RAM.
// Depends on biq_pkg and biq_ram.
//
// Each request carries one signed sample and a channel number; the block returns one filtered,
// rounded and saturated sample per request, in order, through the read and multiply stages and an
// output register. The five Q2.30 coefficients are written through the configuration port and are
// shared by all channels, while each channel keeps its own two previous inputs and outputs in a
// history RAM that reads out on acceptance and is written back when the result leaves the
// arithmetic stage. A request is accepted every cycle while no output stall has backed up to the
// read stage and its channel differs from those of the two requests just ahead of it in the read
// and multiply stages; a request on the same channel as one of them waits for that history
// write-back. History reads as zero after reset through per-channel valid flags, so no clearing
// pass is needed. Channel numbers at or above CHANNEL_COUNT give a zero sample and leave history alone.
module biquad_iir_filter import biq_pkg::*; #(
  parameter int CHANNEL_COUNT = 8,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [COEF_BITS-1:0]          cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] audio_in,
  input  logic [CHAN_BITS-1:0]          channel_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] audio_out,
  output logic [CHAN_BITS-1:0]          channel_out,
  output logic                          clipped
);

  localparam int AW = CHANNEL_COUNT > 1 ? $clog2(CHANNEL_COUNT) : 1;
  localparam int HW = 4 * SAMPLE_BITS;
  localparam int PW = COEF_BITS + SAMPLE_BITS;
  localparam int SW = PW + 4;
  localparam int RW = SW - COEF_FRAC;
  localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [COEF_BITS-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;

  logic accept, hazard, in_range, out_free, s1_free, s2_free, s1_move;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en;
  logic [HW-1:0] rd_data, wr_data, hist;
  logic [CHANNEL_COUNT-1:0] hist_valid;

  logic s1_valid, s1_in_range, s1_hist_ok;
  logic signed [SAMPLE_BITS-1:0] s1_x;
  logic [CHAN_BITS-1:0] s1_ch;
  logic signed [SAMPLE_BITS-1:0] h_x1, h_x2, h_y1, h_y2;
  logic signed [PW-1:0] m_b0, m_b1, m_b2, m_a1, m_a2;

  logic s2_valid, s2_in_range;
  logic [CHAN_BITS-1:0] s2_ch;
  logic signed [SAMPLE_BITS-1:0] s2_x, s2_x1, s2_y1;
  logic signed [PW-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;

  logic signed [SW-1:0] sum;
  logic [RW-1:0] rounded;
  logic over;
  logic signed [SAMPLE_BITS-1:0] y;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= COEF_ONE;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_B0: coef_b0 <= cfg_data;
        REG_B1: coef_b1 <= cfg_data;
        REG_B2: coef_b2 <= cfg_data;
        REG_A1: coef_a1 <= cfg_data;
        REG_A2: coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign s2_free  = !s2_valid || out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign s1_move  = s1_valid && s2_free;
  assign hazard   = (s1_valid && s1_ch == channel_in) || (s2_valid && s2_ch == channel_in);
  assign in_stall = !s1_free || hazard;
  assign accept   = in_valid && !in_stall;
  assign in_range = 32'(channel_in) < CHANNEL_COUNT;
  assign rd_addr  = AW'(channel_in);

  biq_ram #(
    .WIDTH(HW),
    .DEPTH(CHANNEL_COUNT)
  ) u_hist_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (accept),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_x        <= audio_in;
      s1_ch       <= channel_in;
      s1_in_range <= in_range;
      s1_hist_ok  <= in_range && hist_valid[rd_addr];
    end
  end

  assign hist = s1_hist_ok ? rd_data : '0;
  assign {h_x1, h_x2, h_y1, h_y2} = hist;

  assign m_b0 = coef_b0 * s1_x;
  assign m_b1 = coef_b1 * h_x1;
  assign m_b2 = coef_b2 * h_x2;
  assign m_a1 = coef_a1 * h_y1;
  assign m_a2 = coef_a2 * h_y2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
    if (s1_move) begin
      p_b0        <= m_b0;
      p_b1        <= m_b1;
      p_b2        <= m_b2;
      p_a1        <= m_a1;
      p_a2        <= m_a2;
      s2_ch       <= s1_ch;
      s2_in_range <= s1_in_range;
      s2_x        <= s1_x;
      s2_x1       <= h_x1;
      s2_y1       <= h_y1;
    end
  end

  always_comb begin
    sum = SW'(p_b0) + SW'(p_b1) + SW'(p_b2) - SW'(p_a1) - SW'(p_a2) + ROUND_HALF;
    rounded = sum[SW-1:COEF_FRAC];
    over = !(&rounded[RW-1:SAMPLE_BITS-1]) && (|rounded[RW-1:SAMPLE_BITS-1]);
    if (over) begin
      y = rounded[RW-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      y = rounded[SAMPLE_BITS-1:0];
    end
  end

  assign wr_en   = s2_valid && out_free && s2_in_range;
  assign wr_addr = AW'(s2_ch);
  assign wr_data = {s2_x, s2_x1, y, s2_y1};

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
    end else if (wr_en) begin
      hist_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
    if (s2_valid && out_free) begin
      audio_out   <= s2_in_range ? y : '0;
      clipped     <= s2_in_range && over;
      channel_out <= s2_ch;
    end
  end

endmodule

/* rtl/biq_checker.sv */
// Port-level assertions for the biquad IIR filter, attached by a bind statement.
// Depends on biq_pkg and on the biquad_iir_filter top level.
module biq_port_checker import biq_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [CHAN_BITS-1:0]          channel_in,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] audio_out,
  input logic [CHAN_BITS-1:0]          channel_out,
  input logic                          clipped
);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result presented straight after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(audio_out) && $stable(channel_out)
      && $stable(clipped))
    else $error("stalled result changed or vanished");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> audio_out == SAMPLE_MAX || audio_out == SAMPLE_MIN)
    else $error("clipped result is not at a saturation limit");

  a_same_channel_waits: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 (in_valid && channel_in == $past(channel_in)) |-> in_stall)
    else $error("request on the same channel accepted before history write-back");

endmodule

bind biquad_iir_filter biq_port_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_biq_checker (.*);

/* sim/biq_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the biquad IIR filter: follows the coefficient port, requests and results,
// predicts every filtered sample and compares it field by field with the one returned.
// Depends on biq_pkg.
module biq_checker import biq_pkg::*; #(
  parameter int CHANNEL_COUNT = 8,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [COEF_BITS-1:0]          cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] audio_in,
  input  logic [CHAN_BITS-1:0]          channel_in,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_BITS-1:0] audio_out,
  input  logic [CHAN_BITS-1:0]          channel_out,
  input  logic                          clipped,
  output int                            mismatch_count,
  output int                            outstanding,
  output int                            clip_count
);

  localparam int NUM_COEFS = REG_A2 + 1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] level;
    logic [CHAN_BITS-1:0]          chan;
    logic                          sat;
  } filtered_t;

  longint coef [NUM_COEFS];
  longint last_in [CHANNEL_COUNT];
  longint older_in [CHANNEL_COUNT];
  longint last_out [CHANNEL_COUNT];
  longint older_out [CHANNEL_COUNT];
  filtered_t awaited_samples [$];

  function automatic filtered_t filter_sample(input logic signed [SAMPLE_BITS-1:0] x,
                                              input logic [CHAN_BITS-1:0] ch);
    longint sum;
    longint y;
    longint top_val;
    longint bottom_val;
    filtered_t res;
    top_val = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    bottom_val = -top_val - 1;
    res.chan = ch;
    res.level = '0;
    res.sat = 1'b0;
    if (ch < CHANNEL_COUNT) begin
      sum = coef[REG_B0] * longint'(x) + coef[REG_B1] * last_in[ch]
          + coef[REG_B2] * older_in[ch] - coef[REG_A1] * last_out[ch]
          - coef[REG_A2] * older_out[ch];
      y = (sum + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      if (y > top_val) begin
        y = top_val;
        res.sat = 1'b1;
      end else if (y < bottom_val) begin
        y = bottom_val;
        res.sat = 1'b1;
      end
      older_in[ch] = last_in[ch];
      last_in[ch] = longint'(x);
      older_out[ch] = last_out[ch];
      last_out[ch] = y;
      res.level = y[SAMPLE_BITS-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    filtered_t want;
    int i;
    if (rst) begin
      coef[REG_B0] = longint'(COEF_ONE);
      for (i = REG_B1; i < NUM_COEFS; i++) coef[i] = 0;
      for (i = 0; i < CHANNEL_COUNT; i++) begin
        last_in[i] = 0;
        older_in[i] = 0;
        last_out[i] = 0;
        older_out[i] = 0;
      end
      awaited_samples.delete();
      mismatch_count = 0;
      clip_count = 0;
    end else begin
      if (cfg_write && cfg_index < NUM_COEFS) coef[cfg_index] = longint'($signed(cfg_data));
      if (out_valid && !out_stall) begin
        if (awaited_samples.size() == 0) begin
          $display("%0t: sample %0d on channel %0d returned with no request outstanding",
                   $time, audio_out, channel_out);
          mismatch_count++;
        end else begin
          want = awaited_samples.pop_front();
          if (audio_out !== want.level) begin
            $display("%0t: audio_out expected %0d, got %0d", $time, want.level, audio_out);
            mismatch_count++;
          end
          if (channel_out !== want.chan) begin
            $display("%0t: channel_out expected %0d, got %0d", $time, want.chan, channel_out);
            mismatch_count++;
          end
          if (clipped !== want.sat) begin
            $display("%0t: clipped expected %0b, got %0b", $time, want.sat, clipped);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = filter_sample(audio_in, channel_in);
        if (want.sat) clip_count++;
        awaited_samples.push_back(want);
      end
    end
    outstanding = awaited_samples.size();
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// Top level of the biquad IIR filter testbench: clock, reset, coefficient sets and sample
// requests with random gaps and output stalls. Depends on biq_pkg, biquad_iir_filter and
// biq_checker, which compares every returned sample with its prediction.
module tb;
  import biq_pkg::*;

  localparam int CHANNEL_COUNT = 8;
  localparam int SAMPLE_BITS = 24;
  localparam int RANDOM_SAMPLES = 1450;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 10;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic signed [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam logic signed [COEF_BITS-1:0] COEF_HALF = COEF_ONE >>> 1;

  typedef enum logic [1:0] {PACE_NONE, PACE_SOME, PACE_ALWAYS} pace_t;
  typedef enum logic [1:0] {STYLE_GENTLE, STYLE_WILD, STYLE_EDGE} coef_style_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
  logic [COEF_BITS-1:0]          cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] audio_in = '0;
  logic [CHAN_BITS-1:0]          channel_in = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] audio_out;
  logic [CHAN_BITS-1:0]          channel_out;
  logic                          clipped;
  int                            mismatch_count;
  int                            outstanding;
  int                            clip_count;

  pace_t send_pace = PACE_NONE;
  pace_t recv_pace = PACE_NONE;
  int    stall_left = 0;
  int    cycle_count = 0;
  int    samples_sent = 0;
  int    filter_sets = 0;

  always #5 clk = ~clk;

  biquad_iir_filter #(
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .audio_in(audio_in),
    .channel_in(channel_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .audio_out(audio_out),
    .channel_out(channel_out),
    .clipped(clipped)
  );

  biq_checker #(
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .audio_in(audio_in),
    .channel_in(channel_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .audio_out(audio_out),
    .channel_out(channel_out),
    .clipped(clipped),
    .mismatch_count(mismatch_count),
    .outstanding(outstanding),
    .clip_count(clip_count)
  );

  function automatic int draw_wait(input pace_t pace);
    case (pace)
      PACE_NONE: return 0;
      PACE_SOME: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 19) : 0;
      default: return $urandom_range(0, 19);
    endcase
  endfunction

  function automatic logic [COEF_BITS-1:0] pick_edge_coef();
    case ($urandom_range(0, 4))
      0: return COEF_MIN;
      1: return COEF_MAX;
      2: return '0;
      3: return COEF_ONE;
      default: return -COEF_ONE;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) stall_left = draw_wait(recv_pace);
      else if (stall_left != 0) stall_left--;
      out_stall <= stall_left != 0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               CYCLE_LIMIT, outstanding);
      $display("** biquad_iir_filter: FAILED **");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x,
                             input logic [CHAN_BITS-1:0] ch);
    int gap;
    gap = draw_wait(send_pace);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    audio_in <= x;
    channel_in <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [COEF_BITS-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Coefficients change only once every request has returned; each set also pokes an
  // index past the last coefficient, which the block must ignore.
  task automatic set_filter(input logic [COEF_BITS-1:0] b0, b1, b2, a1, a2);
    drain();
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    write_reg(CFG_INDEX_BITS'($urandom_range((1 << CFG_INDEX_BITS) - 1, REG_A2 + 1)),
              $urandom());
    cfg_write <= 1'b0;
    filter_sets++;
  endtask

  initial begin
    int target;
    int phase_len;
    int amp_shift;
    int k;
    longint half_span;
    longint pole_span;
    longint a1_span;
    longint cb0, cb1, cb2, ca1, ca2;
    logic [CHAN_BITS-1:0] burst_chan;
    logic [CHAN_BITS-1:0] ch;
    logic signed [SAMPLE_BITS-1:0] x;
    coef_style_t style;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset coefficients pass every sample straight through.
    send_sample(SAMPLE_MAX, 0);
    send_sample(SAMPLE_MIN, 1);
    send_sample('0, 7);
    send_sample(-1, 3);
    send_sample(1, 3);

    // A gain of one half lands exactly on the rounding ties.
    set_filter(COEF_HALF, '0, '0, '0, '0);
    send_sample(1, 4);
    send_sample(-1, 5);
    send_sample(3, 6);
    send_sample(-3, 4);

    // Most negative coefficients, back to back on one channel, saturating at the negative limit.
    set_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_sample(SAMPLE_MAX, 2);
    send_sample(SAMPLE_MAX, 2);
    send_sample(SAMPLE_MIN, 2);
    send_sample(SAMPLE_MIN, 2);
    send_sample('0, 2);

    send_pace = PACE_SOME;
    recv_pace <= PACE_SOME;
    set_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_sample(SAMPLE_MIN, 6);
    send_sample(SAMPLE_MAX, 6);
    send_sample('0, 5);
    send_sample(SAMPLE_MAX, 6);

    half_span = longint'(COEF_HALF);
    pole_span = longint'(COEF_ONE) * 4 / 5;
    target = samples_sent + RANDOM_SAMPLES;
    while (samples_sent < target) begin
      send_pace = pace_t'($urandom_range(0, 2));
      recv_pace <= pace_t'($urandom_range(0, 2));
      style = ($urandom_range(0, 2) != 0) ? STYLE_GENTLE
                                          : coef_style_t'($urandom_range(1, 2));
      case (style)
        STYLE_GENTLE: begin
          cb0 = longint'($urandom_range(0, 2 * half_span)) - half_span;
          cb1 = longint'($urandom_range(0, 2 * half_span)) - half_span;
          cb2 = longint'($urandom_range(0, 2 * half_span)) - half_span;
          ca2 = longint'($urandom_range(0, 2 * pole_span)) - pole_span;
          a1_span = (longint'(COEF_ONE) + ca2) * 9 / 10;
          ca1 = longint'($urandom_range(0, 2 * a1_span)) - a1_span;
        end
        STYLE_WILD: begin
          cb0 = longint'($urandom());
          cb1 = longint'($urandom());
          cb2 = longint'($urandom());
          ca1 = longint'($urandom());
          ca2 = longint'($urandom());
        end
        default: begin
          cb0 = longint'(pick_edge_coef());
          cb1 = longint'(pick_edge_coef());
          cb2 = longint'(pick_edge_coef());
          ca1 = longint'(pick_edge_coef());
          ca2 = longint'(pick_edge_coef());
        end
      endcase
      set_filter(COEF_BITS'(cb0), COEF_BITS'(cb1), COEF_BITS'(cb2),
                 COEF_BITS'(ca1), COEF_BITS'(ca2));

      phase_len = $urandom_range(60, 200);
      amp_shift = $urandom_range(0, 12);
      burst_chan = CHAN_BITS'($urandom_range(0, (1 << CHAN_BITS) - 1));
      for (k = 0; k < phase_len && samples_sent < target; k++) begin
        if ($urandom_range(0, 199) == 0) drain();
        ch = ($urandom_range(0, 3) == 0) ? burst_chan
                                         : CHAN_BITS'($urandom_range(0, (1 << CHAN_BITS) - 1));
        case ($urandom_range(0, 15))
          0: x = SAMPLE_MAX;
          1: x = SAMPLE_MIN;
          2, 3: x = SAMPLE_BITS'($urandom());
          default: begin
            x = SAMPLE_BITS'($urandom());
            x = x >>> amp_shift;
          end
        endcase
        send_sample(x, ch);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d samples over %0d channels under %0d coefficient sets;",
             samples_sent, CHANNEL_COUNT, filter_sets);
    $display("%0d of the filtered samples were expected to saturate.", clip_count);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("** biquad_iir_filter: PASSED **");
    end else begin
      $display("** biquad_iir_filter: FAILED **");
    end
    $finish;
  end

endmodule
